// ===== design/bth_pkg.sv =====
// ----------------------------------------------------------------------------
// bth_pkg
// Shared types, codes and default parameter values for the BER TLV header
// parser.
// ----------------------------------------------------------------------------
package bth_pkg;

	localparam int TAG_BITS_DEF          = 21;
	localparam int MAX_LENGTH_OCTETS_DEF = 4;
	localparam int OFFSET_BITS_DEF       = 32;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_LENGTH = 2'd1;
	localparam logic [1:0] ERR_TAG    = 2'd2;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_CONTENT = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [20:0] tag_number;
		logic        constructed;
		logic [31:0] length;
		logic        indefinite;
		logic        end_of_contents;
		logic [31:0] header_offset;
		logic [1:0]  error_code;
		logic [7:0]  content_byte;
		logic        content_last;
	} res_word_t;

endpackage

// ===== design/bth_chan_if.sv =====
// ----------------------------------------------------------------------------
// bth_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface bth_chan_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/bth_in_stage.sv =====
// ----------------------------------------------------------------------------
// bth_in_stage
// Input register: holds one stream byte until the parser consumes it.
// ----------------------------------------------------------------------------
module bth_in_stage
	import bth_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic [7:0] data_byte,
	input  logic       advance,
	output logic       ready,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic take;

	assign ready = !valid_s1 || advance;
	assign take  = valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload: load on accept
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

// ===== design/bth_engine.sv =====
// ----------------------------------------------------------------------------
// bth_engine
// Phase machine and accumulators; builds one result word per consumed byte
// when a header completes or a content byte passes.
// ----------------------------------------------------------------------------
module bth_engine
	import bth_pkg::*;
#(
	parameter int TAG_BITS          = TAG_BITS_DEF,
	parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEF,
	parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_s1,
	output logic       res_valid,
	output res_word_t  res_word
);

	typedef enum logic [2:0] {
		PH_TAG_FIRST,
		PH_TAG_EXT,
		PH_LEN_FIRST,
		PH_LEN_LONG,
		PH_CONTENT
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [TAG_BITS-1:0]    tag_q, tag_d;
	logic                   cons_q, cons_d;
	logic [31:0]            len_q, len_d;
	logic [6:0]             left_q, left_d;
	logic [31:0]            cont_q, cont_d;
	logic [OFFSET_BITS-1:0] byte_off_q;
	logic [OFFSET_BITS-1:0] tag_off_q, tag_off_d;
	logic [1:0]             err_q, err_d;

	logic [TAG_BITS+6:0]    tag_ext;
	logic                   tag_ovf;
	logic [6:0]             left_dec;
	logic [31:0]            cont_dec;
	logic                   hdr_go;
	logic                   hdr_indef;
	logic [1:0]             hdr_code;
	logic [31:0]            hdr_len;
	logic                   hdr_eoc;
	logic                   hdr_body;
	logic                   produced;
	logic [31:0]            tag_wide;
	logic [63:0]            off_wide;

	assign tag_ext  = {tag_q, byte_s1[6:0]};
	assign tag_ovf  = |tag_ext[TAG_BITS+6 -: 7];
	assign left_dec = left_q - 7'((left_q != 7'd0) ? 1 : 0);
	assign cont_dec = cont_q - 32'((cont_q != 32'd0) ? 1 : 0);
	assign tag_wide = 32'(tag_q);
	assign off_wide = 64'(tag_off_q);

	always_comb begin
		phase_d   = phase_q;
		tag_d     = tag_q;
		cons_d    = cons_q;
		len_d     = len_q;
		left_d    = left_q;
		cont_d    = cont_q;
		tag_off_d = tag_off_q;
		err_d     = err_q;
		hdr_go    = 1'b0;
		hdr_indef = 1'b0;
		produced  = 1'b0;
		res_word  = '0;

		case (phase_q)
			PH_TAG_FIRST: begin
				err_d     = 2'b00;
				len_d     = '0;
				cons_d    = byte_s1[5];
				tag_off_d = byte_off_q;
				if (byte_s1[4:0] == 5'h1f) begin
					tag_d   = '0;
					phase_d = PH_TAG_EXT;
				end else begin
					tag_d   = TAG_BITS'(byte_s1[4:0]);
					phase_d = PH_LEN_FIRST;
				end
			end
			PH_TAG_EXT: begin
				// saturate once the tag outgrows its width; keep eating octets
				if (err_q[1] || tag_ovf) begin
					err_d[1] = 1'b1;
					tag_d    = '1;
				end else begin
					tag_d = tag_ext[TAG_BITS-1:0];
				end
				tag_off_d = byte_off_q;
				if (!byte_s1[7]) begin
					phase_d = PH_LEN_FIRST;
				end
			end
			PH_LEN_FIRST: begin
				if (!byte_s1[7]) begin
					len_d  = 32'(byte_s1);
					hdr_go = 1'b1;
				end else if (byte_s1[6:0] == 7'd0) begin
					len_d     = '0;
					hdr_go    = 1'b1;
					hdr_indef = 1'b1;
				end else begin
					left_d = byte_s1[6:0];
					len_d  = '0;
					if (byte_s1[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
						err_d[0] = 1'b1;
					end
					phase_d = PH_LEN_LONG;
				end
			end
			PH_LEN_LONG: begin
				if (!err_q[0] && (|len_q[31:24])) begin
					err_d[0] = 1'b1;
				end
				if (err_d[0]) begin
					len_d = '1;
				end else begin
					len_d = {len_q[23:0], byte_s1};
				end
				left_d = left_dec;
				if (left_dec == 7'd0) begin
					hdr_go = 1'b1;
				end
			end
			PH_CONTENT: begin
				produced              = 1'b1;
				res_word.result_kind  = KIND_CONTENT;
				res_word.content_byte = byte_s1;
				res_word.content_last = (cont_q <= 32'd1);
				cont_d                = cont_dec;
				if (cont_dec == 32'd0) begin
					phase_d = PH_TAG_FIRST;
				end
			end
			default: begin
				phase_d = PH_TAG_FIRST;
			end
		endcase

		// header completion, shared by the short, indefinite and long forms
		hdr_code = err_d[1] ? ERR_TAG : (err_d[0] ? ERR_LENGTH : ERR_NONE);
		hdr_len  = hdr_indef ? 32'd0 : len_d;
		hdr_body = (hdr_code == ERR_NONE) && !hdr_indef && !cons_q;
		hdr_eoc  = hdr_body && (tag_q == '0) && (hdr_len == 32'd0);
		if (hdr_go) begin
			produced                 = 1'b1;
			res_word.result_kind     = KIND_HEADER;
			res_word.tag_number      = tag_wide[20:0];
			res_word.constructed     = cons_q;
			res_word.length          = hdr_len;
			res_word.indefinite      = hdr_indef;
			res_word.end_of_contents = hdr_eoc;
			res_word.header_offset   = off_wide[31:0];
			res_word.error_code      = hdr_code;
			if (hdr_body && (hdr_len != 32'd0)) begin
				cont_d  = hdr_len;
				phase_d = PH_CONTENT;
			end else begin
				phase_d = PH_TAG_FIRST;
			end
		end
	end

	assign res_valid = advance && produced;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG_FIRST;
			tag_q      <= '0;
			cons_q     <= 1'b0;
			len_q      <= '0;
			left_q     <= '0;
			cont_q     <= '0;
			byte_off_q <= '0;
			tag_off_q  <= '0;
			err_q      <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			tag_q      <= tag_d;
			cons_q     <= cons_d;
			len_q      <= len_d;
			left_q     <= left_d;
			cont_q     <= cont_d;
			byte_off_q <= byte_off_q + OFFSET_BITS'(1);
			tag_off_q  <= tag_off_d;
			err_q      <= err_d;
		end
	end

endmodule

// ===== design/bth_out_stage.sv =====
// ----------------------------------------------------------------------------
// bth_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module bth_out_stage
	import bth_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  res_word_t res_word,
	input  logic      ready,
	output logic      can_load,
	output logic      valid,
	output res_word_t data
);

	logic valid_q;
	res_word_t data_q;

	assign can_load = !valid_q || ready;
	assign valid    = valid_q;
	assign data     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_word;
		end
	end

endmodule

// ===== design/ber_tlv_header_parser.sv =====
// A result word is built from its byte while that byte waits in the input
// register, and is loaded into the result register when the parser advances.
// Throughput: one byte per cycle, set by the phase update between the input
// register and the result register; bytes stall only while a result waits and
// the sink holds ready low. Reset: arst_n clears the valid flags and parser
// state; the parser then expects a first tag octet at stream offset zero.
// ----------------------------------------------------------------------------
// ber_tlv_header_parser
// BER TLV header parser: walks a byte stream through tag, length and
// primitive content phases; reports each header and passes content bytes.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser
	import bth_pkg::*;
#(
	parameter int TAG_BITS          = TAG_BITS_DEF,
	parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEF,
	parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bth_chan_if.sink   byte_stream,
	bth_chan_if.source results
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       can_load;
	logic       res_valid;
	res_word_t  res_word;
	in_word_t   in_word;
	res_word_t  out_word;

	assign in_word      = byte_stream.data;
	assign results.data = out_word;

	// Advance the parser whenever a byte waits and the result register is
	// free or draining this cycle; bytes without a result advance the same way.
	assign advance = valid_s1 && can_load;

	// Hold the incoming word until the parser consumes it.
	bth_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (byte_stream.valid),
		.data_byte (in_word.data_byte),
		.advance   (advance),
		.ready     (byte_stream.ready),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	// Update phase and accumulators; build the header or content word.
	bth_engine #(
		.TAG_BITS          (TAG_BITS),
		.MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS),
		.OFFSET_BITS       (OFFSET_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res_word  (res_word)
	);

	// Register the result word; take a new one while the old one drains.
	bth_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res_word (res_word),
		.ready    (results.ready),
		.can_load (can_load),
		.valid    (results.valid),
		.data     (out_word)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream check of the BER TLV header parser. A scoreboard class keeps
// its own copy of the parse state, predicts the header and content words for
// every accepted byte and compares them field by field with what the block
// returns. Stimulus is a short hand-picked stream followed by randomly built
// elements (mostly well formed, some oversized or garbled), sent in bursts
// while the result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;
	import bth_pkg::*;

	localparam int RANDOM_BYTES = 1350;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [63:0] TAG_MAX = (64'd1 << TAG_BITS_DEF) - 64'd1;

	// Parse phases of the predicted block.
	typedef enum logic [2:0] {
		ST_TAG,
		ST_TAG_EXT,
		ST_LEN,
		ST_LEN_LONG,
		ST_BODY
	} parse_phase_e;

	// Result-side stall patterns.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_QUARTER,
		RX_BURSTY
	} rx_mode_e;

	// ------------------------------------------------------------------------
	// Header/content predictor and result checker.
	// ------------------------------------------------------------------------
	class tlv_scoreboard;
		parse_phase_e                  ph;
		logic [TAG_BITS_DEF-1:0]       tag_acc;
		logic                          cons;
		logic [31:0]                   len_acc;
		logic [6:0]                    len_left;
		logic [31:0]                   body_left;
		logic [OFFSET_BITS_DEF-1:0]    byte_off;
		logic [OFFSET_BITS_DEF-1:0]    tag_off;
		logic [1:0]                    err_flags;
		res_word_t                     expected_q [$];
		int                            mismatches;

		function new();
			ph         = ST_TAG;
			tag_acc    = '0;
			cons       = 1'b0;
			len_acc    = '0;
			len_left   = '0;
			body_left  = '0;
			byte_off   = '0;
			tag_off    = '0;
			err_flags  = '0;
			mismatches = 0;
		endfunction

		function res_word_t header(bit indef);
			res_word_t   w;
			logic [1:0]  code;
			logic [31:0] len;
			code = err_flags[1] ? ERR_TAG : (err_flags[0] ? ERR_LENGTH : ERR_NONE);
			len  = indef ? 32'd0 : len_acc;
			w = '0;
			w.result_kind     = KIND_HEADER;
			w.tag_number      = tag_acc;
			w.constructed     = cons;
			w.length          = len;
			w.indefinite      = indef;
			w.end_of_contents = (code == ERR_NONE) && !indef && !cons &&
				(tag_acc == '0) && (len == 32'd0);
			w.header_offset   = 32'(tag_off);
			w.error_code      = code;
			if (code == ERR_NONE && !indef && !cons && len != 32'd0) begin
				body_left = len;
				ph = ST_BODY;
			end else begin
				ph = ST_TAG;
			end
			return w;
		endfunction

		// Advance the parse state by one byte; return 1 when a word results.
		function bit step(logic [7:0] b, output res_word_t w);
			logic [63:0]                nxt;
			logic [OFFSET_BITS_DEF-1:0] here;
			bit                         got;
			got = 1'b0;
			w = '0;
			here = byte_off;
			byte_off = byte_off + 1'b1;
			case (ph)
				ST_TAG: begin
					err_flags = '0;
					len_acc = '0;
					cons = b[5];
					tag_off = here;
					if (b[4:0] == 5'h1f) begin
						tag_acc = '0;
						ph = ST_TAG_EXT;
					end else begin
						tag_acc = TAG_BITS_DEF'(b[4:0]);
						ph = ST_LEN;
					end
				end
				ST_TAG_EXT: begin
					nxt = (64'(tag_acc) << 7) | 64'(b[6:0]);
					// saturate a tag that no longer fits
					if (err_flags[1] || nxt > TAG_MAX) begin
						err_flags[1] = 1'b1;
						nxt = TAG_MAX;
					end
					tag_acc = nxt[TAG_BITS_DEF-1:0];
					tag_off = here;
					if (!b[7])
						ph = ST_LEN;
				end
				ST_LEN: begin
					if (b < 8'h80) begin
						len_acc = 32'(b);
						got = 1'b1;
						w = header(1'b0);
					end else if (b == 8'h80) begin
						len_acc = '0;
						got = 1'b1;
						w = header(1'b1);
					end else begin
						len_left = b[6:0];
						len_acc = '0;
						if (len_left > MAX_LENGTH_OCTETS_DEF)
							err_flags[0] = 1'b1;
						ph = ST_LEN_LONG;
					end
				end
				ST_LEN_LONG: begin
					if (!err_flags[0] && len_acc[31:24] != 8'd0)
						err_flags[0] = 1'b1;
					if (err_flags[0])
						len_acc = '1;
					else
						len_acc = {len_acc[23:0], b};
					if (len_left > 0)
						len_left = len_left - 1'b1;
					if (len_left == 0) begin
						got = 1'b1;
						w = header(1'b0);
					end
				end
				ST_BODY: begin
					got = 1'b1;
					w.result_kind  = KIND_CONTENT;
					w.content_byte = b;
					w.content_last = (body_left <= 32'd1);
					if (body_left > 0)
						body_left = body_left - 1'b1;
					if (body_left == 0)
						ph = ST_TAG;
				end
				default: ph = ST_TAG;
			endcase
			return got;
		endfunction

		function void note_byte(logic [7:0] b);
			res_word_t w;
			if (step(b, w))
				expected_q.push_back(w);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void cmp(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				$error("%s: expected %0h, actual %0h", name, e, a);
				mismatches++;
			end
		endfunction

		function void check_word(res_word_t act);
			res_word_t exp;
			if (expected_q.size() == 0) begin
				$error("result word %h arrived with nothing expected", act);
				mismatches++;
				return;
			end
			exp = expected_q.pop_front();
			cmp("result_kind", 64'(exp.result_kind), 64'(act.result_kind));
			cmp("tag_number", 64'(exp.tag_number), 64'(act.tag_number));
			cmp("constructed", 64'(exp.constructed), 64'(act.constructed));
			cmp("length", 64'(exp.length), 64'(act.length));
			cmp("indefinite", 64'(exp.indefinite), 64'(act.indefinite));
			cmp("end_of_contents", 64'(exp.end_of_contents),
				64'(act.end_of_contents));
			cmp("header_offset", 64'(exp.header_offset), 64'(act.header_offset));
			cmp("error_code", 64'(exp.error_code), 64'(act.error_code));
			cmp("content_byte", 64'(exp.content_byte), 64'(act.content_byte));
			cmp("content_last", 64'(exp.content_last), 64'(act.content_last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bth_chan_if #(.payload_t(in_word_t))  byte_if ();
	bth_chan_if #(.payload_t(res_word_t)) res_if ();

	ber_tlv_header_parser uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_if),
		.results     (res_if)
	);

	// sb tracks what the block has accepted; plan tracks what has been
	// generated so far, so the element builder knows the phase it is in.
	tlv_scoreboard sb;
	tlv_scoreboard plan;

	logic [7:0] opening_seq [$];
	int         sent_count;
	int         burst_left;
	int         cycle_count = 0;
	rx_mode_e   rx_mode = RX_OPEN;
	logic [5:0] rx_tick = '0;

	always #5 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Check every word the result side takes.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_word(res_if.data);
	end

	// Result-side stalls: pick a random pattern whenever the 6-bit rx_tick wraps.
	always @(negedge clk) begin
		if (rx_tick == 6'd0)
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
		rx_tick <= rx_tick + 1'b1;
		case (rx_mode)
			RX_OPEN:    res_if.ready <= 1'b1;
			RX_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
			RX_QUARTER: res_if.ready <= (rx_tick[1:0] == 2'd0);
			default:    res_if.ready <= (rx_tick[3:0] >= 4'd11);
		endcase
	end

	// Present one byte, starting and ending on a falling edge. Insert an
	// idle gap between bursts; hold the word until the block takes it.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
			if (gap > 0) begin
				byte_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		byte_if.valid <= 1'b1;
		byte_if.data.data_byte <= b;
		@(posedge clk);
		while (!byte_if.ready)
			@(posedge clk);
		sb.note_byte(b);
		sent_count++;
		@(negedge clk);
	endtask

	// Generate one byte: advance the planner, then drive it.
	task automatic put(input logic [7:0] b);
		res_word_t unused;
		bit        dummy;
		dummy = plan.step(b, unused);
		send_byte(b);
	endtask

	// Hold the stream until every expected word has come back.
	task automatic drain_pause();
		byte_if.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Tag octets: short form, or extended with ext_octets base-128 octets.
	// The leading extended octet always carries its top value bit, so four or
	// more of them always overflow the tag width.
	task automatic gen_tag(input logic cons, input int ext_octets);
		logic [7:0] b;
		int         i;
		b = 8'($urandom);
		b[5] = cons;
		if (ext_octets == 0) begin
			if (b[4:0] == 5'h1f)
				b[4:0] = 5'($urandom_range(0, 30));
			put(b);
		end else begin
			b[4:0] = 5'h1f;
			put(b);
			for (i = 0; i < ext_octets; i++) begin
				b = 8'($urandom);
				b[7] = (i != ext_octets - 1);
				if (i == 0)
					b[6] = 1'b1;
				put(b);
			end
		end
	endtask

	// Definite length: short form when long_octets is zero, else big endian.
	task automatic gen_len(input logic [31:0] value, input int long_octets);
		int i;
		if (long_octets == 0) begin
			put({1'b0, value[6:0]});
		end else begin
			put(8'h80 | 8'(long_octets));
			for (i = long_octets - 1; i >= 0; i--)
				put(value[8*i +: 8]);
		end
	endtask

	// More length octets than the block accepts.
	task automatic gen_overlong_len();
		int n;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 127) : $urandom_range(5, 8);
		put(8'h80 | 8'(n));
		repeat (n) put(8'($urandom));
	endtask

	// Any length field, for headers that carry no content.
	task automatic gen_any_len();
		case ($urandom_range(0, 3))
			0: put(8'($urandom_range(0, 127)));
			1: put(8'h80);
			2: gen_len($urandom, $urandom_range(1, 4));
			default: gen_overlong_len();
		endcase
	endtask

	// Random bytes; keep a length octet from asking for a huge body, and run
	// on until the stream is back at a first tag octet.
	task automatic gen_noise();
		logic [7:0] b;
		int         n;
		int         i;
		n = $urandom_range(1, 8);
		i = 0;
		while (i < n || plan.ph != ST_TAG) begin
			b = 8'($urandom);
			if (plan.ph == ST_LEN && b >= 8'h81 && b <= 8'h84)
				b[7] = 1'b0;
			put(b);
			i++;
		end
	endtask

	// One random element.
	task automatic gen_element();
		int          r;
		logic [31:0] len;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			// primitive with a body, mostly short
			gen_tag(1'b0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			gen_len(len, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
			repeat (len) put(8'($urandom));
		end else if (r < 62) begin
			// empty primitive; end-of-contents pair now and then
			if ($urandom_range(0, 1) == 0) begin
				put(8'h00);
				put(8'h00);
			end else begin
				gen_tag(1'b0, $urandom_range(0, 2));
				gen_len(32'd0, $urandom_range(0, 2));
			end
		end else if (r < 77) begin
			// constructed: whatever length, the body parses as new elements
			gen_tag(1'b1, $urandom_range(0, 3));
			gen_any_len();
		end else if (r < 82) begin
			// indefinite primitive, no body follows
			gen_tag(1'b0, $urandom_range(0, 3));
			put(8'h80);
		end else if (r < 87) begin
			// tag too wide
			gen_tag(1'($urandom_range(0, 1)), $urandom_range(4, 6));
			gen_any_len();
		end else if (r < 92) begin
			// length too long
			gen_tag(1'($urandom_range(0, 1)), $urandom_range(0, 3));
			gen_overlong_len();
		end else begin
			gen_noise();
		end
	endtask

	initial begin
		bit paused;
		sb   = new();
		plan = new();
		sent_count  = 0;
		burst_left  = 0;
		paused      = 1'b0;
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.data  = '0;

		// end of contents; widest tag that fits, indefinite primitive;
		// constructed with long length; two-byte and one-byte bodies;
		// too many length octets
		opening_seq = '{
			8'h00, 8'h00,
			8'h1f, 8'hff, 8'hff, 8'h7f, 8'h80,
			8'h24, 8'h81, 8'hff,
			8'h02, 8'h02, 8'hab, 8'hcd,
			8'h03, 8'h01, 8'hff,
			8'h05, 8'h85, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_seq[i])
			put(opening_seq[i]);
		drain_pause();

		while (sent_count < opening_seq.size() + RANDOM_BYTES) begin
			if (!paused && sent_count > opening_seq.size() + RANDOM_BYTES / 2) begin
				paused = 1'b1;
				drain_pause();
			end
			gen_element();
		end

		// Drop valid, drain, then give the pipeline time to show extras.
		byte_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== ber_tlv_header_parser.f =====
design/bth_pkg.sv
design/bth_chan_if.sv
design/bth_in_stage.sv
design/bth_engine.sv
design/bth_out_stage.sv
design/ber_tlv_header_parser.sv
dv/tb.sv
